// ----- src/sts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Types, register indexes and constants shared by the symbol timing slicer.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int MAX_SAMPLES_PER_SYMBOL = 32;

    // configuration register indexes
    localparam logic [2:0] REG_SPS        = 3'd0;
    localparam logic [2:0] REG_CENTER     = 3'd1;
    localparam logic [2:0] REG_MODULATION = 3'd2;
    localparam logic [2:0] REG_CLIP_MAX   = 3'd3;
    localparam logic [2:0] REG_CLIP_MIN   = 3'd4;
    localparam logic [2:0] REG_CENTER_LVL = 3'd5;
    localparam logic [2:0] REG_MAX_REF    = 3'd6;
    localparam logic [2:0] REG_MIN_REF    = 3'd7;

    // modulation codes
    localparam logic [1:0] MOD_C4FM = 2'd0;
    localparam logic [1:0] MOD_QPSK = 2'd1;
    localparam logic [1:0] MOD_GFSK = 2'd2;

    // timing and window rule constants
    localparam int SPS_LONG       = 20;
    localparam int SPS_SHORT      = 5;
    localparam int LONG_EARLY_LO  = 7;
    localparam int LONG_EARLY_HI  = 10;
    localparam int LONG_LATE_LO   = 11;
    localparam int LONG_LATE_HI   = 14;
    localparam int QPSK_JIT_LIMIT = 10;
    localparam int LONG_WIN_LO    = 9;
    localparam int LONG_WIN_HI    = 11;
    localparam int SHORT_WIN_IDX  = 2;
    localparam int FLIP_SAT       = 127;
    localparam int WIN_MAX        = 7;

    // window sum and divider sizing
    localparam int SUM_W     = 20;
    localparam int DIV_STEPS = 18;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sync_held;
    } sts_in_t;

    typedef struct packed {
        logic signed [15:0] symbol;
        logic [6:0]         flips;
        logic [31:0]        symbol_count;
    } sts_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_EMIT
    } sts_state_t;

endpackage

// ----- src/symbol_timing_slicer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_timing_slicer
// Groups discriminator samples into symbols with jitter-driven timing slip,
// clipping, crossing count and window averaging.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one sample and the sync flag per transfer.
//   m_valid/m_ready/m_data carry one averaged symbol per finished symbol.
//   cfg_wr_en/cfg_addr/cfg_wr_data write a register; write only
//   while no symbol result is outstanding.
//   A sample is registered when taken and processed in the next cycle;
//   s_ready stays low meanwhile. The last sample of a symbol adds a
//   restoring division (one quotient bit per cycle on a shared 4-bit
//   subtractor), so m_valid rises after the division, in the same cycle
//   that s_ready returns.
//   The result sits in an output register; if the receiver stalls while a
//   new result is ready, the block holds it and keeps s_ready low until the
//   output register is free.
//   Reset (aresetn low, synchronous) restores the register defaults, clears
//   the symbol state and counters and drops m_valid.
// ----------------------------------------------------------------------------
module symbol_timing_slicer #(
    parameter int MAX_SPS = sts_pkg::MAX_SAMPLES_PER_SYMBOL
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sts_pkg::sts_in_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output sts_pkg::sts_out_t m_data,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_addr,
    input  logic [15:0]      cfg_wr_data
);
    import sts_pkg::*;

    localparam int IW    = $clog2(MAX_SPS) + 1;         // signed index width
    localparam int CW    = ((IW > 7) ? IW : 7) + 2;     // compare width
    localparam int DSW   = $clog2(DIV_STEPS);
    localparam int DW    = 20;                          // 4x / 5x ref width

    // configuration
    logic [5:0]         cfg_sps_reg;
    logic [4:0]         cfg_center_reg;
    logic [1:0]         cfg_mod_reg;
    logic signed [15:0] cfg_cmax_reg, cfg_cmin_reg, cfg_clev_reg;
    logic signed [15:0] cfg_maxref_reg, cfg_minref_reg;

    // control and symbol state
    sts_state_t          state_reg, state_next;
    logic signed [IW-1:0] sample_index_reg;
    logic signed [IW-1:0] jitter_pos_reg;
    logic signed [15:0]  previous_sample_reg;
    logic signed [SUM_W-1:0] window_sum_reg;
    logic [2:0]          window_count_reg;
    logic [6:0]          flip_count_reg;
    logic [31:0]         symbols_made_reg;

    logic signed [15:0]  in_sample_reg;
    logic                in_sync_reg;

    // divider and pending result
    logic [DIV_STEPS-1:0] div_q_reg;
    logic [2:0]          div_rem_reg;
    logic [2:0]          div_den_reg;
    logic                div_neg_reg;
    logic                div_zero_reg;
    logic [DSW-1:0]      div_step_reg;
    logic [6:0]          pend_flips_reg;
    logic [31:0]         pend_count_reg;

    logic                m_valid_reg;
    sts_out_t            m_data_reg;

    // sequencer controls
    logic in_take, calc_en, div_en, out_load;

    // datapath
    logic signed [CW-1:0] sps_c, ctr_c, j_c, i0_c, i_c, i_inc;
    logic signed [1:0]    adj;
    logic signed [IW-1:0] jit_t, jit_n;
    logic signed [15:0]   s_c;
    logic signed [DW-1:0] s4, last4, hi5, lo5;
    logic                 f_a, f_b, w1, w2, add1, add2, emit;
    logic [7:0]           fsum;
    logic [6:0]           flip_n;
    logic [2:0]           cnt1, cnt_n;
    logic signed [SUM_W-1:0] sum_n, mag;
    logic [3:0]           trial;
    logic                 trial_ok;
    logic [DIV_STEPS-1:0] q_signed;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_sps_reg    <= 6'd10;
            cfg_center_reg <= 5'd4;
            cfg_mod_reg    <= MOD_C4FM;
            cfg_cmax_reg   <= 16'sd15000;
            cfg_cmin_reg   <= -16'sd15000;
            cfg_clev_reg   <= 16'sd0;
            cfg_maxref_reg <= 16'sd12000;
            cfg_minref_reg <= -16'sd12000;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SPS:        cfg_sps_reg    <= cfg_wr_data[5:0];
                REG_CENTER:     cfg_center_reg <= cfg_wr_data[4:0];
                REG_MODULATION: cfg_mod_reg    <= cfg_wr_data[1:0];
                REG_CLIP_MAX:   cfg_cmax_reg   <= cfg_wr_data;
                REG_CLIP_MIN:   cfg_cmin_reg   <= cfg_wr_data;
                REG_CENTER_LVL: cfg_clev_reg   <= cfg_wr_data;
                REG_MAX_REF:    cfg_maxref_reg <= cfg_wr_data;
                REG_MIN_REF:    cfg_minref_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_CALC;
            ST_CALC: state_next = emit ? ST_DIV : ST_IDLE;
            ST_DIV:  if (div_step_reg == '0) state_next = ST_EMIT;
            ST_EMIT: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        calc_en  = 1'b0;
        div_en   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready  = 1'b1;
            ST_CALC: calc_en  = 1'b1;
            ST_DIV:  div_en   = 1'b1;
            ST_EMIT: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // per-sample datapath
    // ------------------------------------------------------------------
    always_comb begin
        sps_c = (CW'(cfg_sps_reg) > CW'(MAX_SPS)) ? CW'(MAX_SPS) : CW'(cfg_sps_reg);
        ctr_c = CW'(cfg_center_reg);
        j_c   = CW'(jitter_pos_reg);
        i0_c  = CW'(sample_index_reg);

        // timing slip at the start of an unsynced symbol
        adj   = 2'sd0;
        jit_t = jitter_pos_reg;
        if (i0_c == '0 && !in_sync_reg) begin
            if (sps_c == CW'(SPS_LONG)) begin
                if (j_c >= CW'(LONG_EARLY_LO) && j_c <= CW'(LONG_EARLY_HI)) begin
                    adj = -2'sd1;
                end else if (j_c >= CW'(LONG_LATE_LO) && j_c <= CW'(LONG_LATE_HI)) begin
                    adj = 2'sd1;
                end
            end else if (cfg_mod_reg == MOD_QPSK) begin
                if (j_c >= 0 && j_c < ctr_c) begin
                    adj = 2'sd1;
                end else if (j_c > ctr_c && j_c < CW'(QPSK_JIT_LIMIT)) begin
                    adj = -2'sd1;
                end
            end else if (cfg_mod_reg == MOD_GFSK) begin
                if (j_c >= ctr_c - 1 && j_c <= ctr_c) begin
                    adj = -2'sd1;
                end else if (j_c >= ctr_c + 1 && j_c <= ctr_c + 2) begin
                    adj = 2'sd1;
                end
            end else if (cfg_mod_reg == MOD_C4FM) begin
                if (j_c > 0 && j_c <= ctr_c) begin
                    adj = -2'sd1;
                end else if (j_c > ctr_c && j_c < sps_c) begin
                    adj = 2'sd1;
                end
            end
            jit_t = -IW'(1);
        end
        i_c = i0_c + CW'(adj);

        // clip while synced in C4FM
        s_c = in_sample_reg;
        if (in_sync_reg && cfg_mod_reg == MOD_C4FM) begin
            if (in_sample_reg > cfg_cmax_reg) begin
                s_c = cfg_cmax_reg;
            end else if (in_sample_reg < cfg_cmin_reg) begin
                s_c = cfg_cmin_reg;
            end
        end

        // 1.25 * ref tested as 4x against 5 * ref
        s4    = DW'(s_c) <<< 2;
        last4 = DW'(previous_sample_reg) <<< 2;
        hi5   = DW'(cfg_maxref_reg) + (DW'(cfg_maxref_reg) <<< 2);
        lo5   = DW'(cfg_minref_reg) + (DW'(cfg_minref_reg) <<< 2);

        f_a   = 1'b0;
        f_b   = 1'b0;
        jit_n = jit_t;
        if (s_c > cfg_clev_reg) begin
            f_a = previous_sample_reg < cfg_clev_reg;
            if (s4 > hi5) begin
                f_b = last4 < hi5;
                if (jit_t < 0 && cfg_mod_reg == MOD_QPSK) jit_n = IW'(i_c);
            end else if (jit_t < 0 && previous_sample_reg < cfg_clev_reg &&
                         cfg_mod_reg != MOD_QPSK) begin
                jit_n = IW'(i_c);
            end
        end else begin
            f_a = previous_sample_reg > cfg_clev_reg;
            if (s4 < lo5) begin
                f_b = last4 > lo5;
                if (jit_t < 0 && cfg_mod_reg == MOD_QPSK) jit_n = IW'(i_c);
            end else if (jit_t < 0 && previous_sample_reg > cfg_clev_reg &&
                         cfg_mod_reg != MOD_QPSK) begin
                jit_n = IW'(i_c);
            end
        end

        fsum   = {1'b0, flip_count_reg} + 8'(f_a) + 8'(f_b);
        flip_n = (fsum > 8'(FLIP_SAT)) ? 7'(FLIP_SAT) : fsum[6:0];

        // averaging window; the long-symbol and mode windows can both hit
        w1 = (sps_c == CW'(SPS_LONG)) && i_c >= CW'(LONG_WIN_LO) && i_c <= CW'(LONG_WIN_HI);
        if (sps_c == CW'(SPS_SHORT)) begin
            w2 = i_c == CW'(SHORT_WIN_IDX);
        end else if (cfg_mod_reg == MOD_C4FM) begin
            w2 = i_c >= ctr_c - 1 && i_c <= ctr_c + 2;
        end else begin
            w2 = i_c == ctr_c - 1 || i_c == ctr_c + 1;
        end
        add1  = w1 && window_count_reg < 3'(WIN_MAX);
        cnt1  = window_count_reg + 3'(add1);
        add2  = w2 && cnt1 < 3'(WIN_MAX);
        cnt_n = cnt1 + 3'(add2);
        sum_n = window_sum_reg + (add1 ? SUM_W'(s_c) : '0) + (add2 ? SUM_W'(s_c) : '0);
        mag   = sum_n[SUM_W-1] ? -sum_n : sum_n;

        i_inc = i_c + CW'(1);
        emit  = !(i_inc < sps_c);
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_sample_reg <= s_data.sample;
            in_sync_reg   <= s_data.sync_held;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg    <= '0;
            jitter_pos_reg      <= -IW'(1);
            previous_sample_reg <= '0;
            window_sum_reg      <= '0;
            window_count_reg    <= '0;
            flip_count_reg      <= '0;
            symbols_made_reg    <= '0;
        end else if (calc_en) begin
            jitter_pos_reg      <= jit_n;
            previous_sample_reg <= s_c;
            if (emit) begin
                sample_index_reg <= '0;
                window_sum_reg   <= '0;
                window_count_reg <= '0;
                flip_count_reg   <= '0;
                symbols_made_reg <= symbols_made_reg + 32'd1;
            end else begin
                sample_index_reg <= IW'(i_inc);
                window_sum_reg   <= sum_n;
                window_count_reg <= cnt_n;
                flip_count_reg   <= flip_n;
            end
        end
    end

    // ------------------------------------------------------------------
    // shared restoring divider: one quotient bit per cycle
    // ------------------------------------------------------------------
    assign trial    = {div_rem_reg, div_q_reg[DIV_STEPS-1]};
    assign trial_ok = trial >= {1'b0, div_den_reg};

    always_ff @(posedge aclk) begin
        if (calc_en && emit) begin
            div_q_reg      <= mag[DIV_STEPS-1:0];
            div_rem_reg    <= '0;
            div_den_reg    <= cnt_n;
            div_neg_reg    <= sum_n[SUM_W-1];
            div_zero_reg   <= cnt_n == '0;
            div_step_reg   <= DSW'(DIV_STEPS - 1);
            pend_flips_reg <= flip_n;
            pend_count_reg <= symbols_made_reg + 32'd1;
        end else if (div_en) begin
            div_rem_reg  <= trial_ok ? 3'(trial - {1'b0, div_den_reg}) : trial[2:0];
            div_q_reg    <= {div_q_reg[DIV_STEPS-2:0], trial_ok};
            div_step_reg <= div_step_reg - 1'b1;
        end
    end

    assign q_signed = div_neg_reg ? (~div_q_reg + 1'b1) : div_q_reg;

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.symbol       <= div_zero_reg ? 16'sd0 : q_signed[15:0];
            m_data_reg.flips        <= pend_flips_reg;
            m_data_reg.symbol_count <= pend_count_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && div_den_reg != '0) |-> div_rem_reg < div_den_reg)
        else $error("divider remainder not below divisor");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && m_valid_reg && !m_ready)
            |=> (state_reg == ST_EMIT && m_valid_reg))
        else $error("pending result overwrote an untaken result");

    a_jitter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !(jitter_pos_reg < -1))
        else $error("jitter position below no-edge marker");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sample_index_reg >= 0) && (CW'(sample_index_reg) < CW'(MAX_SPS)))
        else $error("sample index out of range");

endmodule
